// ----- rtl/grc_pkg.sv -----
// ----------------------------------------------------------------------------
// grc_pkg
// shared constants, types and codes of the grid raycaster
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int MAP_DIM_DEF       = 32;
  localparam int SCREEN_WIDTH_DEF  = 640;
  localparam int SCREEN_HEIGHT_DEF = 480;
  localparam int MAX_STEPS_DEF     = 64;

  localparam int CELL_W  = 4;
  localparam int REG_W   = 10;
  localparam int POS_W   = 13;
  localparam int COL_W   = 10;
  localparam int SPAN_W  = 10;
  // ray component magnitude: |dir*W + plane*cam| < 2^21
  localparam int RAY_W   = 21;
  // side distance numerator, up to 256 + 256*256
  localparam int DIST_W  = 17;
  localparam int PROD_W  = RAY_W + DIST_W;

  localparam logic [1:0] REG_DIR_X   = 2'd0;
  localparam logic [1:0] REG_DIR_Y   = 2'd1;
  localparam logic [1:0] REG_PLANE_X = 2'd2;
  localparam logic [1:0] REG_PLANE_Y = 2'd3;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CAST  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RAY_X, ST_RAY_Y, ST_CMP, ST_STEP, ST_READ,
    ST_TEST, ST_DIV_SETUP, ST_DIV, ST_SPAN, ST_OUT
  } grc_state_t;

  // status from the divider to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } grc_div_stat_t;

endpackage

// ----- rtl/grc_ram.sv -----
// ----------------------------------------------------------------------------
// grc_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module grc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/grc_div.sv -----
// ----------------------------------------------------------------------------
// grc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module grc_div
  import grc_pkg::*;
#(
  parameter int NUM_W = 32,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output grc_div_stat_t    stat
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- rtl/grid_raycast_column.sv -----
// ----------------------------------------------------------------------------
// grid_raycast_column
// fixed-point dda grid raycaster, one screen column per cast item
// ----------------------------------------------------------------------------
// channel  dir  handshake        payload
// in_      in   tvalid/tready    tdata: req_type cell_x cell_y cell_value
//                                column pos_x pos_y
// out_     out  tvalid/tready    tdata: span_start span_end wall_value
//                                hit_side no_hit
// cfg_     in   we               index, 10-bit data
//
// a write item is written in the cycle it is taken; a cast item runs ray setup
// (ST_RAY_X, ST_RAY_Y, ST_CMP), then the states ST_STEP, ST_READ, ST_TEST and
// ST_DIV_SETUP per grid step (two multiplies on the shared multiplier, then a map
// read), up to MAX_STEPS steps, then the height division and ST_SPAN forms the span
// after reset a clearing pass writes zero to every word of the map memory,
// one word a cycle, while no item is accepted (1024 words at the default size)
// the result sits in an output register; the next item is taken once the
// result register is free
// ----------------------------------------------------------------------------
module grid_raycast_column
  import grc_pkg::*;
#(
  parameter int MAP_DIM       = MAP_DIM_DEF,
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int MAX_STEPS     = MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // req_type, cell_x, cell_y, cell_value, column, pos_x, pos_y, zero fill
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // span_start, span_end, wall_value, hit_side, no_hit, zero fill
  output logic [31:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam int MAP_W   = $clog2(MAP_DIM);
  localparam int ADDR_W  = 2 * MAP_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int STEP_W  = $clog2(MAX_STEPS + 1);
  localparam int CAP     = 2 * SCREEN_HEIGHT;
  localparam int LH_W    = $clog2(CAP + 1);
  // numerator H*a and denominator pb*W
  localparam int NUM_W   = RAY_W + 11;
  localparam int DEN_W   = DIST_W + 11;

  // ---------------- input fields
  logic             f_req;
  logic [4:0]       f_cx, f_cy;
  logic [3:0]       f_val;
  logic [COL_W-1:0] f_col;
  logic [POS_W-1:0] f_px, f_py;
  assign f_req = in_tdata[0];
  assign f_cx  = in_tdata[5:1];
  assign f_cy  = in_tdata[10:6];
  assign f_val = in_tdata[14:11];
  assign f_col = in_tdata[24:15];
  assign f_px  = in_tdata[37:25];
  assign f_py  = in_tdata[50:38];

  // ---------------- config registers
  logic signed [REG_W-1:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_x_r   <= -10'sd256;
      dir_y_r   <= '0;
      plane_x_r <= '0;
      plane_y_r <= 10'sd169;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIR_X:   dir_x_r   <= cfg_data;
        REG_DIR_Y:   dir_y_r   <= cfg_data;
        REG_PLANE_X: plane_x_r <= cfg_data;
        REG_PLANE_Y: plane_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- state
  grc_state_t state_r, state_nxt;
  logic [ADDR_W:0]   clr_r, clr_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic signed [MAP_W+1:0] mx_r, mx_nxt, my_r, my_nxt;
  logic sx_r, sx_nxt, sy_r, sy_nxt;           // 1 = negative step
  logic [RAY_W-1:0]  ax_r, ax_nxt, ay_r, ay_nxt;
  logic [DIST_W-1:0] fx_r, fx_nxt, fy_r, fy_nxt, pb_r, pb_nxt;
  logic [RAY_W-1:0]  a_r, a_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;        // fy*ax
  logic side_r, side_nxt;
  logic signed [11:0] cam_r, cam_nxt;
  logic [LH_W-1:0] lh_r, lh_nxt;
  logic [3:0] wval_r, wval_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;

  // ---------------- shared multiplier (one per cycle, registered)
  logic signed [22:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [40:0] mul_p;
  logic signed [40:0] mul_r;
  assign mul_p = mul_a * mul_b;

  // ---------------- map memory
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [3:0]        ram_wdata, ram_rdata;

  grc_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_map (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // ---------------- divider
  logic                div_start;
  logic [NUM_W-1:0]    div_num, div_quo;
  logic [DEN_W-1:0]    div_den;
  grc_div_stat_t       div_stat;

  grc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(div_den), .quo(div_quo), .stat(div_stat)
  );

  logic signed [22:0] ray_sum;
  logic [RAY_W-1:0]   ray_abs;
  logic               takex;
  logic [PROD_W-1:0]  prod_y;
  logic signed [MAP_W+1:0] nmx, nmy;
  logic out_of_map;
  logic [LH_W-1:0] half;
  logic signed [11:0] s_val, e_val;
  logic [9:0] s_clip, e_clip;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    steps_nxt     = steps_r;
    mx_nxt = mx_r; my_nxt = my_r; sx_nxt = sx_r; sy_nxt = sy_r;
    ax_nxt = ax_r; ay_nxt = ay_r; fx_nxt = fx_r; fy_nxt = fy_r;
    pb_nxt = pb_r; a_nxt = a_r; prod_nxt = prod_r; side_nxt = side_r;
    cam_nxt = cam_r; lh_nxt = lh_r; wval_nxt = wval_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_r[ADDR_W-1:0];
    ram_wdata = '0;
    ram_raddr = {mx_r[MAP_W-1:0], my_r[MAP_W-1:0]};
    div_start = 1'b0;
    div_num   = NUM_W'(a_r) * NUM_W'(SCREEN_HEIGHT);
    div_den   = DEN_W'(pb_r) * DEN_W'(SCREEN_WIDTH);
    mul_a = '0;
    mul_b = '0;
    ray_sum = 23'(mul_r);
    ray_abs = ray_sum[22] ? RAY_W'(-ray_sum) : RAY_W'(ray_sum);
    prod_y  = PROD_W'(mul_r);
    if (ax_r == '0 && ay_r == '0) takex = fx_r < fy_r;
    else                          takex = prod_r < prod_y;
    nmx = (MAP_W+2)'(mx_r + (sx_r ? -1 : 1));
    nmy = (MAP_W+2)'(my_r + (sy_r ? -1 : 1));
    out_of_map = (mx_r < 0) || (mx_r >= MAP_DIM) || (my_r < 0) || (my_r >= MAP_DIM);
    half   = lh_r >> 1;
    s_val  = 12'(SCREEN_HEIGHT / 2) - 12'(half);
    e_val  = 12'(half) + 12'(SCREEN_HEIGHT / 2);
    s_clip = s_val < 0 ? '0 : s_val[9:0];
    e_clip = e_val >= SCREEN_HEIGHT ? 10'(SCREEN_HEIGHT - 1) : e_val[9:0];

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (ADDR_W+1)'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = !out_valid_r;
        if (in_tvalid && in_tready) begin
          if (f_req == REQ_WRITE) begin
            ram_waddr = {f_cx[MAP_W-1:0], f_cy[MAP_W-1:0]};
            ram_wdata = f_val;
            ram_we    = (32'(f_cx) < MAP_DIM) && (32'(f_cy) < MAP_DIM);
          end else begin
            cam_nxt = 12'($signed({1'b0, f_col}) * 2 - SCREEN_WIDTH);
            mx_nxt  = (MAP_W+2)'(f_px >> 8);
            my_nxt  = (MAP_W+2)'(f_py >> 8);
            fx_nxt  = DIST_W'(f_px[7:0]);
            fy_nxt  = DIST_W'(f_py[7:0]);
            steps_nxt = '0;
            if (32'(f_px >> 8) >= MAP_DIM || 32'(f_py >> 8) >= MAP_DIM) begin
              out_data_nxt  = 32'(1) << 25;
              out_valid_nxt = 1'b1;
            end else begin
              state_nxt = ST_RAY_X;
            end
          end
        end
      end
      ST_RAY_X: begin
        // mul_r <= plane_x*cam, then add dir_x*W
        mul_a = 23'(plane_x_r);
        mul_b = 18'(cam_r);
        state_nxt = ST_RAY_Y;
      end
      ST_RAY_Y: begin
        ray_sum = 23'(mul_r) + 23'(dir_x_r) * 23'(SCREEN_WIDTH);
        ray_abs = ray_sum[22] ? RAY_W'(-ray_sum) : RAY_W'(ray_sum);
        ax_nxt = ray_abs;
        sx_nxt = ray_sum[22];
        if (!ray_sum[22]) fx_nxt = DIST_W'(256) - fx_r;
        mul_a = 23'(plane_y_r);
        mul_b = 18'(cam_r);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // finishes the y component
        state_nxt = ST_STEP;
        mul_a = 23'(ax_r);
        mul_b = 18'(fy_r);
      end
      default: ;
    endcase
    // step walk
    unique case (state_r)
      ST_STEP: begin
        prod_nxt = PROD_W'(mul_r);      // fy*ax
        mul_a = 23'(ay_r);
        mul_b = 18'(fx_r);
        state_nxt = ST_READ;
      end
      ST_READ: begin
        // mul_r = fx*ay, prod_r = fy*ax
        if (ax_r == '0 && ay_r == '0) takex = fx_r < fy_r;
        else                          takex = PROD_W'(mul_r) < prod_r;
        steps_nxt = steps_r + 1'b1;
        if (takex) begin
          pb_nxt = fx_r; a_nxt = ax_r; fx_nxt = fx_r + DIST_W'(256);
          mx_nxt = nmx; side_nxt = 1'b0;
        end else begin
          pb_nxt = fy_r; a_nxt = ay_r; fy_nxt = fy_r + DIST_W'(256);
          my_nxt = nmy; side_nxt = 1'b1;
        end
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        // address settles here, data is in ram_rdata next
        if (out_of_map) begin
          out_data_nxt  = 32'(1) << 25;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DIV_SETUP;
        end
      end
      ST_DIV_SETUP: begin
        wval_nxt = ram_rdata;
        if (ram_rdata != '0) begin
          if (a_r == '0) begin
            lh_nxt = '0; state_nxt = ST_SPAN;
          end else if (pb_r == '0) begin
            lh_nxt = LH_W'(CAP); state_nxt = ST_SPAN;
          end else begin
            div_start = 1'b1; state_nxt = ST_DIV;
          end
        end else if (32'(steps_r) >= MAX_STEPS) begin
          out_data_nxt  = 32'(1) << 25;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          mul_a = 23'(ax_r);
          mul_b = 18'(fy_r);
          state_nxt = ST_STEP;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          lh_nxt = (div_quo > NUM_W'(CAP)) ? LH_W'(CAP) : LH_W'(div_quo);
          state_nxt = ST_SPAN;
        end
      end
      ST_SPAN: begin
        out_data_nxt  = {6'd0, 1'b0, side_r, wval_r, e_clip, s_clip};
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: ;
    endcase
    if (state_r == ST_CMP) begin
      // y component lands here from ST_RAY_Y multiply
      ray_sum = 23'(mul_r) + 23'(dir_y_r) * 23'(SCREEN_WIDTH);
      ray_abs = ray_sum[22] ? RAY_W'(-ray_sum) : RAY_W'(ray_sum);
      ay_nxt = ray_abs;
      sy_nxt = ray_sum[22];
      if (!ray_sum[22]) fy_nxt = DIST_W'(256) - fy_r;
      // fy*ax uses the final fy: restart multiply in ST_STEP path
      mul_a = 23'(ax_r);
      mul_b = 18'(ray_sum[22] ? fy_r : DIST_W'(256) - fy_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    steps_r <= steps_nxt;
    mx_r <= mx_nxt; my_r <= my_nxt; sx_r <= sx_nxt; sy_r <= sy_nxt;
    ax_r <= ax_nxt; ay_r <= ay_nxt; fx_r <= fx_nxt; fy_r <= fy_nxt;
    pb_r <= pb_nxt; a_r <= a_nxt; prod_r <= prod_nxt; side_r <= side_nxt;
    cam_r <= cam_nxt; lh_r <= lh_nxt; wval_r <= wval_nxt;
    out_data_r <= out_data_nxt;
    mul_r <= mul_p;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // result register holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed under stall");
  // no item taken while clearing the map
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_tready)
    else $error("ready during clear");
  // divider only runs in its wait state
  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == ST_DIV)
    else $error("divider busy outside division");

endmodule

// ----- dv/grc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_checker
// watches the item, result and register ports of the raycaster, predicts
// every column result and compares it field by field
// ----------------------------------------------------------------------------
module grc_checker
  import grc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  output int          pending,
  output int          errors
);

  localparam longint W = SCREEN_WIDTH_DEF;
  localparam longint H = SCREEN_HEIGHT_DEF;

  // highest field first, span_start in the lowest bits
  typedef struct packed {
    logic       no_hit;
    logic       hit_side;
    logic [3:0] wall_value;
    logic [9:0] span_end;
    logic [9:0] span_start;
  } span_t;

  logic [CELL_W-1:0] map_cells [MAP_DIM_DEF*MAP_DIM_DEF];
  logic signed [REG_W-1:0] dir_x, dir_y, plane_x, plane_y;
  span_t spans_due [$];

  function automatic span_t trace_column(logic [9:0] col, logic [12:0] px,
                                         logic [12:0] py);
    longint cam, nx, ny, ax, ay, fx, fy, pb, a, lh, half, s, e;
    int mx, my, sx, sy;
    bit takex, side;
    span_t r;
    r = '0;
    r.no_hit = 1'b1;
    cam = 2 * longint'(col) - W;
    nx = longint'(dir_x) * W + longint'(plane_x) * cam;
    ny = longint'(dir_y) * W + longint'(plane_y) * cam;
    ax = nx < 0 ? -nx : nx;
    ay = ny < 0 ? -ny : ny;
    sx = nx < 0 ? -1 : 1;
    sy = ny < 0 ? -1 : 1;
    fx = nx < 0 ? longint'(px[7:0]) : 256 - longint'(px[7:0]);
    fy = ny < 0 ? longint'(py[7:0]) : 256 - longint'(py[7:0]);
    mx = int'(px[12:8]);
    my = int'(py[12:8]);
    if (mx >= MAP_DIM_DEF || my >= MAP_DIM_DEF) return r;
    for (int n = 0; n < MAX_STEPS_DEF; n++) begin
      // both axes zero: compare the raw distances, ties go to y
      if (ax == 0 && ay == 0) takex = fx < fy;
      else takex = fx * ay < fy * ax;
      if (takex) begin
        pb = fx; a = ax; fx += 256; mx += sx; side = 1'b0;
      end else begin
        pb = fy; a = ay; fy += 256; my += sy; side = 1'b1;
      end
      if (mx < 0 || mx >= MAP_DIM_DEF || my < 0 || my >= MAP_DIM_DEF) return r;
      if (map_cells[mx*MAP_DIM_DEF + my] != '0) begin
        if (a == 0) lh = 0;            // unbounded distance
        else if (pb == 0) lh = 2 * H;  // standing on the grid line
        else begin
          lh = (H * a) / (pb * W);
          if (lh > 2 * H) lh = 2 * H;
        end
        half = lh / 2;
        s = H / 2 - half;
        e = half + H / 2;
        if (s < 0) s = 0;
        if (e >= H) e = H - 1;
        r.span_start = s[9:0];
        r.span_end   = e[9:0];
        r.wall_value = map_cells[mx*MAP_DIM_DEF + my];
        r.hit_side   = side;
        r.no_hit     = 1'b0;
        return r;
      end
    end
    return r;
  endfunction

  assign pending = spans_due.size();

  always @(posedge clk) begin
    span_t got, want;
    if (!rst_n) begin
      foreach (map_cells[i]) map_cells[i] = '0;
      dir_x = -10'sd256; dir_y = '0; plane_x = '0; plane_y = 10'sd169;
      spans_due.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DIR_X:   dir_x   = cfg_data;
          REG_DIR_Y:   dir_y   = cfg_data;
          REG_PLANE_X: plane_x = cfg_data;
          REG_PLANE_Y: plane_y = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[25:0];
        if (spans_due.size() == 0) begin
          $error("result with nothing expected: %h", got);
          errors <= errors + 1;
        end else begin
          want = spans_due.pop_front();
          if (got != want) begin
            if (got.span_start != want.span_start)
              $error("span_start exp %0d got %0d", want.span_start, got.span_start);
            if (got.span_end != want.span_end)
              $error("span_end exp %0d got %0d", want.span_end, got.span_end);
            if (got.wall_value != want.wall_value)
              $error("wall_value exp %0d got %0d", want.wall_value, got.wall_value);
            if (got.hit_side != want.hit_side)
              $error("hit_side exp %0d got %0d", want.hit_side, got.hit_side);
            if (got.no_hit != want.no_hit)
              $error("no_hit exp %0d got %0d", want.no_hit, got.no_hit);
            errors <= errors + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tdata[0] == REQ_WRITE)
          map_cells[int'(in_tdata[5:1])*MAP_DIM_DEF + int'(in_tdata[10:6])] =
            in_tdata[14:11];
        else
          spans_due.push_back(trace_column(in_tdata[24:15], in_tdata[37:25],
                                           in_tdata[50:38]));
      end
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// random and directed regression of the column raycaster: builds maps,
// casts columns under several view settings and checks every result
// ----------------------------------------------------------------------------
module tb_top;
  import grc_pkg::*;

  localparam int LIMIT       = 2_000_000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 230;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // req_type, cell_x, cell_y, cell_value, column, pos_x, pos_y, zero fill
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // span_start, span_end, wall_value, hit_side, no_hit, zero fill
  logic [31:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_DIR_X;
  logic [9:0]  cfg_data = '0;

  int  pending, errors;
  int  cycles = 0;
  int  sent = 0;
  bit  calm = 1'b0;     // no idling on either side while set
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always #2 clk = ~clk;

  grid_raycast_column u_top (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_index, .cfg_data
  );

  grc_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_index, .cfg_data,
    .pending, .errors
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("grid_raycast_column regression: fail");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (!hold_done && sent == 300) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 37);
    end
  end

  // offer one item, with a random gap first; valid stays up between items unless a gap is drawn
  task automatic push_item(logic [55:0] d);
    while (!calm && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic put_cell(logic [4:0] x, logic [4:0] y, logic [3:0] v);
    push_item({5'b0, 13'd0, 13'd0, 10'd0, v, y, x, REQ_WRITE});
  endtask

  task automatic cast_column(logic [9:0] col, logic [12:0] px, logic [12:0] py);
    push_item({5'b0, py, px, col, 4'd0, 5'd0, 5'd0, REQ_CAST});
  endtask

  task automatic set_view(logic [9:0] dx, logic [9:0] dy, logic [9:0] qx,
                          logic [9:0] qy);
    logic [9:0] v [4];
    v = '{dx, dy, qx, qy};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data  <= v[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // drain all results, then let a trailing cell write settle
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    int kind;
    logic [9:0] views [PHASES][4];
    views[0] = '{-10'sd256, 10'd0, 10'd0, 10'd169};   // reset view
    views[1] = '{10'd511, 10'd511, -10'sd512, -10'sd512};
    views[2] = '{-10'sd512, 10'd0, 10'd0, 10'd511};
    views[3] = '{10'd0, 10'd0, 10'd0, 10'd0};            // no ray at all
    views[4] = '{10'd0, 10'd256, 10'd0, 10'd0};          // x component zero
    views[5] = '{10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom)};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty map, corners, zero-distance wall, screen extremes
    cast_column(10'd320, 13'h0380, 13'h0380);        // empty map, no hit
    put_cell(5'd0, 5'd0, 4'd15);
    put_cell(5'd31, 5'd31, 4'd15);
    put_cell(5'd2, 5'd0, 4'd9);
    cast_column(10'd320, 13'h0300, 13'h0080);        // on a grid line: full span
    cast_column(10'd320, 13'h0380, 13'h0080);
    cast_column(10'd0, 13'h0380, 13'h0080);
    cast_column(10'd1023, 13'h0380, 13'h0080);       // column past screen width
    cast_column(10'd639, 13'h1fff, 13'h1fff);
    cast_column(10'd0, 13'h0000, 13'h0000);
    put_cell(5'd2, 5'd0, 4'd0);                      // clear it again
    cast_column(10'd320, 13'h0300, 13'h0080);
    put_cell(5'd5, 5'd10, 4'd8);
    cast_column(10'd320, 13'h0aff, 13'h0a80);
    settle();

    // walled room so most rays end on a wall
    for (int i = 0; i < 32; i++) begin
      put_cell(5'd0, i[4:0], 4'($urandom_range(15, 1)));
      put_cell(5'd31, i[4:0], 4'($urandom_range(15, 1)));
      put_cell(i[4:0], 5'd0, 4'($urandom_range(15, 1)));
      put_cell(i[4:0], 5'd31, 4'($urandom_range(15, 1)));
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      set_view(views[p][0], views[p][1], views[p][2], views[p][3]);
      calm = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(99);
        if (kind < 15)
          put_cell(5'($urandom_range(30, 1)), 5'($urandom_range(30, 1)),
                   4'($urandom_range(15, 1)));
        else if (kind < 20)
          put_cell(5'($urandom), 5'($urandom), 4'($urandom));  // may open a hole
        else if (kind < 90)
          cast_column(10'($urandom_range(639)), 13'($urandom_range(7935, 256)),
                      13'($urandom_range(7935, 256)));
        else
          cast_column(10'($urandom), 13'($urandom), 13'($urandom));
      end
      calm = 1'b0;
    end

    settle();
    repeat (400) @(posedge clk);
    if (errors == 0)
      $display("grid_raycast_column regression: pass");
    else
      $display("grid_raycast_column regression: fail");
    $finish;
  end

endmodule
